// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned QueueDepth = 256;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned FreqW      = 32;
  localparam int unsigned TagW       = 9;
  localparam int unsigned EntryCntW  = 9;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRemove = 1'b1;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic             mode;
    logic [FreqW-1:0] frequency;
    logic [TagW-1:0]  node_tag;
  } spq_in_t;

  typedef struct packed {
    status_e              status;
    logic [FreqW-1:0]     out_frequency;
    logic [TagW-1:0]      out_tag;
    logic [EntryCntW-1:0] entry_count;
  } spq_out_t;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [TagW-1:0]  tag;
  } entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic   shift_in;
    logic   shift_out;
    entry_t ins;
  } spq_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   lt;
    entry_t entry;
  } cell_link_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spq_ctrl_t  ctrl_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  output cell_link_t link_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   own_lt;

  // Cell stays put when it holds a strictly smaller key than the new entry.
  assign own_lt = valid_q && (entry_q.freq < ctrl_i.ins.freq);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.shift_out) begin
      valid_d = right_i.valid;
      entry_d = right_i.entry;
    end else if (ctrl_i.shift_in && !own_lt) begin
      valid_d = valid_q || left_i.valid;
      entry_d = left_i.lt ? ctrl_i.ins : left_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.lt    = own_lt;
  assign link_o.entry = entry_q;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one insert or remove per cycle; every cell compares its key with the new
// entry in parallel and shifts with its neighbor in the same cycle.
// A stalled result holds off the input; a result being taken lets the next request in.
// Reset (asynchronous, active low) empties the queue and drops any pending result;
// slot payloads are not cleared, only their valid bits.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spq_out_t out_data_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  spq_out_t          out_q, out_d;
  logic              in_xfer;
  logic              is_empty, is_full;
  spq_ctrl_t         ctrl;
  cell_link_t        links [QueueDepth];
  cell_link_t        head_bound, tail_bound;
  logic [31:0]       count_ext;

  // Accept a new request whenever the output register is free or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CountW'(QueueDepth));

  // Broadcast the operation to the chain; refused operations leave cells alone.
  assign ctrl.shift_in  = in_xfer && (in_data_i.mode == ModeInsert) && !is_full;
  assign ctrl.shift_out = in_xfer && (in_data_i.mode == ModeRemove) && !is_empty;
  assign ctrl.ins.freq  = in_data_i.frequency;
  assign ctrl.ins.tag   = in_data_i.node_tag;

  // The head boundary acts as an always-smaller neighbor, so the new entry lands in
  // the first cell whose key is equal or greater. The tail boundary feeds an empty slot.
  assign head_bound.valid = 1'b1;
  assign head_bound.lt    = 1'b1;
  assign head_bound.entry = ctrl.ins;
  assign tail_bound       = '0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    cell_link_t left_link, right_link;
    if (i == 0) begin : g_head
      assign left_link = head_bound;
    end else begin : g_left
      assign left_link = links[i-1];
    end
    if (i == QueueDepth - 1) begin : g_tail
      assign right_link = tail_bound;
    end else begin : g_right
      assign right_link = links[i+1];
    end
    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_link),
      .right_i (right_link),
      .link_o  (links[i])
    );
  end

  // Track the fill level.
  always_comb begin
    count_d = count_q;
    if (ctrl.shift_in) begin
      count_d = count_q + CountW'(1);
    end else if (ctrl.shift_out) begin
      count_d = count_q - CountW'(1);
    end
  end

  assign count_ext = 32'(count_d);

  // Build the result; the head cell holds the least key.
  always_comb begin
    out_d               = '0;
    out_d.entry_count   = count_ext[EntryCntW-1:0];
    if (in_data_i.mode == ModeRemove) begin
      if (is_empty) begin
        out_d.status = StEmpty;
      end else begin
        out_d.status        = StDone;
        out_d.out_frequency = links[0].entry.freq;
        out_d.out_tag       = links[0].entry.tag;
      end
    end else begin
      out_d.status = is_full ? StFull : StDone;
    end
  end

  // Hold the result until transferred; load a new one on every input transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The occupied cells are exactly the first count_q ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    links[0].valid == (count_q != '0))
    else $error("head valid disagrees with fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    links[QueueDepth-1].valid == is_full)
    else $error("tail valid disagrees with fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QueueDepth))
    else $error("fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.shift_out |=> count_q == $past(count_q) - CountW'(1))
    else $error("remove did not drop the fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    links[0].valid && links[1].valid |-> links[0].entry.freq <= links[1].entry.freq)
    else $error("head entries out of order");

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // Cycles without any transfer on either side before the run is declared hung.
  // The longest correct quiet stretch is the receiver hold-off below.
  localparam int unsigned HangLimit   = 4000;
  localparam int unsigned HoldCycles  = 300;

  // Track the sorted contents of the queue and the results they imply.
  class queue_tracker;
    entry_t   sorted_entries[$];
    spq_out_t expected_results[$];
    int       errors;
    int       n_inserts, n_refused, n_removes, n_empty, peak;

    function void note_request(spq_in_t req);
      spq_out_t res;
      entry_t   ent;
      int       pos;
      res        = '0;
      res.status = StDone;
      if (req.mode == ModeInsert) begin
        n_inserts++;
        if (sorted_entries.size() >= QueueDepth) begin
          res.status = StFull;
          n_refused++;
        end else begin
          // Land ahead of every entry with an equal or larger key: ties leave LIFO.
          pos = 0;
          while (pos < sorted_entries.size() && sorted_entries[pos].freq < req.frequency)
            pos++;
          ent.freq = req.frequency;
          ent.tag  = req.node_tag;
          sorted_entries.insert(pos, ent);
        end
      end else begin
        n_removes++;
        if (sorted_entries.size() == 0) begin
          res.status = StEmpty;
          n_empty++;
        end else begin
          ent               = sorted_entries.pop_front();
          res.out_frequency = ent.freq;
          res.out_tag       = ent.tag;
        end
      end
      res.entry_count = EntryCntW'(sorted_entries.size());
      if (sorted_entries.size() > peak) peak = sorted_entries.size();
      expected_results.push_back(res);
    endfunction

    function void check_result(spq_out_t got);
      spq_out_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $error("result with nothing expected: %p", got);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
      if (got.out_frequency !== want.out_frequency) begin
        errors++;
        $error("out_frequency: expected %0h, actual %0h", want.out_frequency, got.out_frequency);
      end
      if (got.out_tag !== want.out_tag) begin
        errors++;
        $error("out_tag: expected %0d, actual %0d", want.out_tag, got.out_tag);
      end
      if (got.entry_count !== want.entry_count) begin
        errors++;
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  spq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  spq_out_t out_data_o;

  queue_tracker tracker = new();
  int           burst_left = 0;
  bit           hold_req   = 1'b0;
  int unsigned  quiet_cycles = 0;

  sorted_priority_queue DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Offer one request and hold it until the block takes it. Requests come in
  // bursts: between bursts, drop valid for a random gap (sometimes none at all,
  // so that valid stays high straight through into the next burst).
  task automatic send_request(input spq_in_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = req;
    // Sample the stall at the rising edge, before the block updates its flops.
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(req);
  endtask

  task automatic send_op(input logic mode, input logic [FreqW-1:0] freq,
                         input logic [TagW-1:0] tag);
    spq_in_t req;
    req.mode      = mode;
    req.frequency = freq;
    req.node_tag  = tag;
    send_request(req);
  endtask

  // Pick a key: mostly full-range, often from a narrow band so that ties
  // happen, now and then one of the two extremes.
  function automatic logic [FreqW-1:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
      1, 2, 3: return FreqW'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Send a random request, an insert with the given odds in percent.
  task automatic send_random(input int insert_pct);
    logic mode;
    mode = ($urandom_range(0, 99) < insert_pct) ? ModeInsert : ModeRemove;
    send_op(mode, pick_freq(), TagW'($urandom_range(0, 511)));
  endtask

  // Stop offering and wait until every result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (tracker.pending() > 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Receiver: stall in segments of random length, each with its own stall
  // density, including stretches with no stall at all. On request, hold off
  // for a long stretch so that the output register and then the input fill up.
  initial begin
    int len;
    int pct;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      len = $urandom_range(5, 60);
      case ($urandom_range(0, 2))
        0:       pct = 0;
        1:       pct = 25;
        default: pct = 60;
      endcase
      repeat (len) begin
        @(negedge clk_i);
        out_stall_i = ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_data_o);
  end

  // Watchdog: count cycles in which neither side transfers anything.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("timeout after %0d cycles without a transfer", HangLimit);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int errors;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: remove on an empty queue, keys at both extremes, three-way
    // tie on one key, ties at the extremes, then drain past empty. Removes
    // carry nonzero payloads, which the block must ignore.
    send_op(ModeRemove, '1, '1);
    send_op(ModeInsert, '1, 9'd511);
    send_op(ModeInsert, '0, 9'd0);
    send_op(ModeInsert, 32'd100, 9'd1);
    send_op(ModeInsert, 32'd100, 9'd2);
    send_op(ModeInsert, 32'd100, 9'd3);
    send_op(ModeInsert, '1, 9'd5);
    send_op(ModeInsert, '0, 9'd6);
    repeat (8) send_op(ModeRemove, 32'h5A5A_A5A5, 9'h155);
    // Pause the sender until everything is back.
    drain_results();

    // Fill: mostly inserts until the queue is full, then a few refused ones.
    // Ask for a long receiver hold-off right at the start of it.
    hold_req = 1'b1;
    while (tracker.sorted_entries.size() < QueueDepth) send_random(95);
    repeat (5) send_random(100);

    // Drain: mostly removes until empty, then a few removes on empty.
    while (tracker.sorted_entries.size() > 0) send_random(5);
    repeat (5) send_random(0);

    drain_results();
    repeat (10) @(posedge clk_i);

    errors = tracker.errors + tracker.pending();
    $display("Ran %0d inserts (%0d refused as full) and %0d removes (%0d on empty),",
             tracker.n_inserts, tracker.n_refused, tracker.n_removes, tracker.n_empty);
    $display("occupancy peaked at %0d of %0d entries; %0d mismatches.",
             tracker.peak, QueueDepth, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
